/* rtl/bolec_pkg.sv */
package bolec_pkg;

   // payload widths
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_HEAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FOOT   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   // chain commands
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FOOT   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd4;

   // per-cell operations
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_HOLD       = 2'd0;
   localparam logic [OP_W-1:0] OP_TAKE_LEFT  = 2'd1;
   localparam logic [OP_W-1:0] OP_TAKE_RIGHT = 2'd2;
   localparam logic [OP_W-1:0] OP_LOAD       = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] operand;
   } chain_req_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] head;
   } chain_stat_type;

endpackage

/* rtl/bolec_if.sv */
interface bolec_req_if import bolec_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

interface bolec_rsp_if import bolec_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] data;
   logic [COUNT_W-1:0]       count;
   logic                     last;

   modport source (output valid, output status, output data, output count, output last,
                   input ready);
   modport sink (input valid, input status, input data, input count, input last,
                 output ready);
endinterface

/* rtl/bolec_cell.sv */
module bolec_cell import bolec_pkg::*; (
   input  logic              clock,
   input  logic [OP_W-1:0]   op,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   input  logic [DATA_W-1:0] load_data,
   input  logic [DATA_W-1:0] operand,
   output logic [DATA_W-1:0] data,
   output logic              equal
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // pick the next entry from a neighbor, the load bus or self
   always_comb begin
      case (op)
         OP_TAKE_LEFT:  data_in = left_data;
         OP_TAKE_RIGHT: data_in = right_data;
         OP_LOAD:       data_in = load_data;
         default:       data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign equal = (data_ff == operand);

endmodule

/* rtl/bolec_chain.sv */
module bolec_chain import bolec_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  chain_req_type                      chain_req,
   input  logic [$clog2(CAPACITY+1)-1:0]      count,
   output chain_stat_type                     chain_stat
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [DATA_W-1:0]   cell_data [CAPACITY];
   logic [CAPACITY-1:0] cell_equal;
   logic [CAPACITY-1:0] cell_used;
   logic [CAPACITY-1:0] match;
   logic [DATA_W-1:0]   load_data;
   logic [CW-1:0]       count_m1;

   assign count_m1  = count - 1'b1;
   assign match     = cell_equal & cell_used;
   // rotate feeds the head back in at the foot
   assign load_data = (chain_req.cmd == CMD_ROTATE) ? cell_data[0] : chain_req.operand;

   assign chain_stat.hit  = |match;
   assign chain_stat.head = cell_data[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;
      logic              hit_upto;

      assign cell_used[i] = (CW'(i) < count);
      assign hit_upto     = |match[i:0];

      if (i == 0) begin : g_first
         assign left_data = load_data;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_final
         assign right_data = cell_data[i];
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      // decode the chain command for this cell
      always_comb begin
         case (chain_req.cmd)
            CMD_HEAD:   op = OP_TAKE_LEFT;
            CMD_FOOT:   op = (CW'(i) == count) ? OP_LOAD : OP_HOLD;
            CMD_DELETE: op = (hit_upto && cell_used[i]) ? OP_TAKE_RIGHT : OP_HOLD;
            CMD_ROTATE: begin
               if (!cell_used[i]) begin
                  op = OP_HOLD;
               end else if (CW'(i) == count_m1) begin
                  op = OP_LOAD;
               end else begin
                  op = OP_TAKE_RIGHT;
               end
            end
            default:    op = OP_HOLD;
         endcase
      end

      bolec_cell u_cell (
         .clock      (clock),
         .op         (op),
         .left_data  (left_data),
         .right_data (right_data),
         .load_data  (load_data),
         .operand    (chain_req.operand),
         .data       (cell_data[i]),
         .equal      (cell_equal[i])
      );
   end

endmodule

/* rtl/bounded_ordered_list_engine_core.sv */
// channel   | dir | handshake              | payload
// req_chan  | in  | valid/ready            | kind[1:0], value[31:0] signed
// rsp_chan  | out | valid/ready            | status[1:0], data[31:0], count[4:0], last
//
// Insert and delete requests give one response each.
// Read all gives one response per entry, the chain rotating one entry to the
// head per cycle while the response can load; no request is taken meanwhile.
// Synchronous reset empties the list; cell contents are not cleared.
// A stalled response holds; a new request is taken when the output
// register is empty or being drained in the same cycle.
module bounded_ordered_list_engine_core import bolec_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   bolec_req_if.sink   req_chan,
   bolec_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       remain_ff, remain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   chain_req_type  chain_req;
   chain_stat_type chain_stat;

   logic load_ok;
   logic accept;
   logic rsp_load;
   logic full;
   logic empty;

   assign load_ok  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && load_ok;
   assign accept   = req_chan.valid && req_chan.ready;
   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);

   // sequence requests and read-all streaming
   always_comb begin
      logic [CW+COUNT_W-1:0] count_ext;
      logic [CW-1:0]         count_out;

      state_in          = state_ff;
      count_in          = count_ff;
      remain_in         = remain_ff;
      rsp_load          = 1'b0;
      rsp_status_in     = ST_DONE;
      rsp_data_in       = req_chan.value;
      rsp_last_in       = 1'b1;
      count_out         = count_ff;
      chain_req.cmd     = CMD_NONE;
      chain_req.operand = req_chan.value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.kind)
                  KIND_HEAD, KIND_FOOT: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        chain_req.cmd = (req_chan.kind == KIND_HEAD) ? CMD_HEAD : CMD_FOOT;
                        count_in      = count_ff + 1'b1;
                        count_out     = count_in;
                     end
                  end
                  KIND_DELETE: begin
                     rsp_load = 1'b1;
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (!chain_stat.hit) begin
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        chain_req.cmd = CMD_DELETE;
                        count_in      = count_ff - 1'b1;
                        count_out     = count_in;
                     end
                  end
                  default: begin
                     if (empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_data_in   = '0;
                     end else begin
                        state_in  = ST_READ;
                        remain_in = count_ff;
                     end
                  end
               endcase
            end
         end
         default: begin
            // emit the head, then rotate it to the foot
            if (load_ok) begin
               rsp_load      = 1'b1;
               chain_req.cmd = CMD_ROTATE;
               rsp_data_in   = chain_stat.head;
               rsp_last_in   = (remain_ff == CW'(1));
               remain_in     = remain_ff - 1'b1;
               if (remain_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase

      count_ext    = {{COUNT_W{1'b0}}, count_out};
      rsp_count_in = count_ext[COUNT_W-1:0];

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.count  = rsp_count_ff;
   assign rsp_chan.last   = rsp_last_ff;

   bolec_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock      (clock),
      .chain_req  (chain_req),
      .count      (count_ff),
      .chain_stat (chain_stat)
   );

   // list never grows past its capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // read-all bookkeeping stays within the list
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (remain_ff != '0 && remain_ff <= count_ff))
      else $error("read-all remainder out of range");

   // read-all leaves the list size untouched
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> $stable(count_ff))
      else $error("count changed during read-all");

   // final read-all response returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && load_ok && remain_ff == CW'(1)) |=> (state_ff == ST_IDLE))
      else $error("read-all did not finish");

   // a non-final response only comes from a read-all in progress
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == ST_READ))
      else $error("non-final response outside read-all");

endmodule
